/* rtl/core/lps_pkg.sv */
// shared constants, types and sequencer states of the line position steering unit
`default_nettype none

package lps_pkg;

    // block configuration
    localparam int CHANNELS     = 5;
    localparam int SAMPLE_BITS  = 12;

    // fixed scaling and steering constants
    localparam int SCALE_FULL   = 1000;
    localparam int CENTER       = 2000;
    localparam int THRESH_RESET = 500;
    localparam int THRESH_BITS  = 11;
    localparam int POS_BITS     = 12;
    localparam int POS_MAX      = 4095;
    localparam int ERR_BITS     = 12;
    localparam int ERR_MAX      = 2047;
    localparam int ERR_MIN      = -2048;

    // derived widths
    localparam int CH_BITS      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LV_BITS      = $clog2(SCALE_FULL + 1);
    localparam int NUM_BITS     = SAMPLE_BITS + LV_BITS;
    localparam int WEIGHT_MAX   = SCALE_FULL * (CHANNELS - 1);
    localparam int WEIGHT_BITS  = $clog2(WEIGHT_MAX + 1);
    localparam int SUM_BITS     = $clog2(SCALE_FULL * CHANNELS + 1);
    localparam int WSUM_BITS    =
        $clog2(SCALE_FULL * SCALE_FULL * CHANNELS * (CHANNELS - 1) / 2 + 1);

    // shared divider sizing
    localparam int DIV_N        = (NUM_BITS > WSUM_BITS) ? NUM_BITS : WSUM_BITS;
    localparam int DIV_D        = (SAMPLE_BITS > SUM_BITS) ? SAMPLE_BITS : SUM_BITS;
    localparam int CNT_BITS     = $clog2(DIV_N + 1);
    localparam int SCALE_QBITS  = LV_BITS;
    localparam int POS_QBITS    = WEIGHT_BITS;

    // stream widths
    localparam int IN_WIDTH     = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_WIDTH    = 32;

    // divider request from the sequencer
    typedef struct packed {
        logic                start;
        logic [CNT_BITS-1:0] iters;
        logic [DIV_N-1:0]    dividend;
        logic [DIV_D-1:0]    divisor;
    } div_req_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic             done;
        logic             busy;
        logic [DIV_N-1:0] quotient;
    } div_rsp_t;

    // sequencer states, one-hot
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CAL   = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_SDIV  = 8'b0000_1000,
        S_ACC   = 8'b0001_0000,
        S_CENT  = 8'b0010_0000,
        S_CDIV  = 8'b0100_0000,
        S_STEER = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/lps_div.sv */
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module lps_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lps_pkg::div_req_t req,
    output lps_pkg::div_rsp_t      rsp
);

    logic [lps_pkg::DIV_D-1:0]    rem_reg, rem_next;
    logic [lps_pkg::DIV_N-1:0]    quo_reg, quo_next;
    logic [lps_pkg::DIV_D-1:0]    divisor_reg;
    logic [lps_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [lps_pkg::DIV_D:0]      trial;
    logic                         ge;
    logic [lps_pkg::CNT_BITS-1:0] lshift;

    // trial subtract for the current step
    assign trial  = {rem_reg, quo_reg[lps_pkg::DIV_N-1]};
    assign ge     = (trial >= {1'b0, divisor_reg});
    assign lshift = lps_pkg::CNT_BITS'(lps_pkg::DIV_N) - req.iters;

    // next state of the iteration
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            // preload so that only the requested number of steps remain
            rem_next  = lps_pkg::DIV_D'(req.dividend >> req.iters);
            quo_next  = req.dividend << lshift;
            cnt_next  = req.iters;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? lps_pkg::DIV_D'(trial - {1'b0, divisor_reg})
                          : trial[lps_pkg::DIV_D-1:0];
            quo_next = {quo_reg[lps_pkg::DIV_N-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == lps_pkg::CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
        begin
            divisor_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/core/line_position_steering_unit.sv */
// top level of the line position steering unit: calibration, centroid and steering sequencer
//
// usage
//   s_tvalid/s_tready/s_tdata: one request carries one raw sample per light sensor
//   channel. m_tvalid/m_tready/m_tdata/m_tuser: one result per request with the line
//   position, the error from center and the two motor enables; m_tuser flags no line.
//   cfg_valid/cfg_ready/cfg_data writes the steering threshold; cfg_ready is always high.
// timing
//   a request runs per channel through the min/max update, the scaling setup, the shared
//   divider (10 quotient bits) and accumulation; then through the centroid setup, the
//   centroid division and the steering step. a flat channel skips its division and no
//   line skips the centroid division. s_tready is high only while the sequencer is
//   idle, so a new request is taken only once the last one has left the steering step.
// reset
//   rst_n clears the calibration to max 0 and min full scale, the threshold to 500
//   and drops m_tvalid.
// stall
//   a finished result waits in the output register; the next request is accepted and
//   processed meanwhile, and its steering cycle holds until the register frees up.
`default_nettype none

module line_position_steering_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // sample_0 .. sample_N from bit 0 up, zero padded
    input  wire logic [lps_pkg::IN_WIDTH-1:0]    s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // line_position[11:0], position_error[23:12], left_on[24], right_on[25], zero pad
    output logic [lps_pkg::OUT_WIDTH-1:0]        m_tdata,
    // no_line
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // steer_threshold
    input  wire logic [lps_pkg::THRESH_BITS-1:0] cfg_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready
);

    lps_pkg::state_t                      state_reg, state_next;
    logic [lps_pkg::CH_BITS-1:0]          ch_reg;
    logic [lps_pkg::SAMPLE_BITS-1:0]      samp_reg [lps_pkg::CHANNELS];
    logic [lps_pkg::SAMPLE_BITS-1:0]      max_reg  [lps_pkg::CHANNELS];
    logic [lps_pkg::SAMPLE_BITS-1:0]      min_reg  [lps_pkg::CHANNELS];
    logic [lps_pkg::THRESH_BITS-1:0]      thr_reg;
    logic [lps_pkg::LV_BITS-1:0]          lv_reg;
    logic [lps_pkg::SUM_BITS-1:0]         sum_reg;
    logic [lps_pkg::WSUM_BITS-1:0]        wsum_reg;
    logic [lps_pkg::WEIGHT_BITS-1:0]      weight_reg;
    logic [lps_pkg::POS_BITS-1:0]         pos_reg;
    logic                                 none_reg;
    logic [lps_pkg::POS_BITS-1:0]         pos_out_reg;
    logic [lps_pkg::ERR_BITS-1:0]         err_out_reg;
    logic                                 left_out_reg;
    logic                                 right_out_reg;
    logic                                 none_out_reg;
    logic                                 m_tvalid_reg;

    logic                                 in_acc;
    logic                                 out_acc;
    logic                                 out_free;
    logic [lps_pkg::SAMPLE_BITS-1:0]      cur_samp;
    logic [lps_pkg::SAMPLE_BITS-1:0]      cur_max;
    logic [lps_pkg::SAMPLE_BITS-1:0]      cur_min;
    logic [lps_pkg::SAMPLE_BITS-1:0]      span;
    logic [lps_pkg::NUM_BITS-1:0]         scaled_num;
    logic [lps_pkg::WSUM_BITS-1:0]        wterm;
    logic                                 last_ch;
    logic [lps_pkg::DIV_N-1:0]            pos_clamp;
    logic signed [lps_pkg::ERR_BITS:0]    err_wide;
    logic signed [lps_pkg::ERR_BITS:0]    err_sat;
    logic signed [lps_pkg::ERR_BITS:0]    thr_s;
    logic [lps_pkg::THRESH_BITS-1:0]      thr_eff;
    lps_pkg::div_req_t                    div_req;
    lps_pkg::div_rsp_t                    div_rsp;

    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid_reg && m_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == lps_pkg::S_IDLE);
    assign cfg_ready = 1'b1;

    // current channel operands
    assign cur_samp   = samp_reg[ch_reg];
    assign cur_max    = max_reg[ch_reg];
    assign cur_min    = min_reg[ch_reg];
    assign span       = cur_max - cur_min;
    assign scaled_num = lps_pkg::NUM_BITS'(cur_samp - cur_min)
                      * lps_pkg::NUM_BITS'(lps_pkg::SCALE_FULL);
    assign wterm      = lps_pkg::WSUM_BITS'(lv_reg) * lps_pkg::WSUM_BITS'(weight_reg);
    assign last_ch    = (ch_reg == lps_pkg::CH_BITS'(lps_pkg::CHANNELS - 1));

    // centroid saturation
    assign pos_clamp  = (div_rsp.quotient > lps_pkg::DIV_N'(lps_pkg::POS_MAX))
                      ? lps_pkg::DIV_N'(lps_pkg::POS_MAX) : div_rsp.quotient;

    // error from center and threshold compare
    assign err_wide = $signed({1'b0, pos_reg}) - (lps_pkg::ERR_BITS + 1)'(lps_pkg::CENTER);
    always_comb
    begin
        err_sat = err_wide;
        if (err_wide > (lps_pkg::ERR_BITS + 1)'(lps_pkg::ERR_MAX))
        begin
            err_sat = (lps_pkg::ERR_BITS + 1)'(lps_pkg::ERR_MAX);
        end
        else if (err_wide < (lps_pkg::ERR_BITS + 1)'(lps_pkg::ERR_MIN))
        begin
            err_sat = (lps_pkg::ERR_BITS + 1)'(lps_pkg::ERR_MIN);
        end
    end
    assign thr_eff = (thr_reg == '0) ? lps_pkg::THRESH_BITS'(1) : thr_reg;
    assign thr_s   = $signed((lps_pkg::ERR_BITS + 1)'(thr_eff));

    // divider requests: channel scaling or centroid
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.iters    = lps_pkg::CNT_BITS'(lps_pkg::SCALE_QBITS);
        div_req.dividend = lps_pkg::DIV_N'(scaled_num);
        div_req.divisor  = lps_pkg::DIV_D'(span);
        if (state_reg == lps_pkg::S_CENT)
        begin
            div_req.iters    = lps_pkg::CNT_BITS'(lps_pkg::POS_QBITS);
            div_req.dividend = lps_pkg::DIV_N'(wsum_reg);
            div_req.divisor  = lps_pkg::DIV_D'(sum_reg);
            div_req.start    = (sum_reg != '0);
        end
        else if (state_reg == lps_pkg::S_MUL)
        begin
            div_req.start = (span != '0);
        end
    end

    lps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lps_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = lps_pkg::S_CAL;
                end
            end
            lps_pkg::S_CAL:
            begin
                state_next = lps_pkg::S_MUL;
            end
            lps_pkg::S_MUL:
            begin
                state_next = (span != '0) ? lps_pkg::S_SDIV : lps_pkg::S_ACC;
            end
            lps_pkg::S_SDIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = lps_pkg::S_ACC;
                end
            end
            lps_pkg::S_ACC:
            begin
                state_next = last_ch ? lps_pkg::S_CENT : lps_pkg::S_CAL;
            end
            lps_pkg::S_CENT:
            begin
                state_next = (sum_reg != '0) ? lps_pkg::S_CDIV : lps_pkg::S_STEER;
            end
            lps_pkg::S_CDIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = lps_pkg::S_STEER;
                end
            end
            lps_pkg::S_STEER:
            begin
                if (out_free)
                begin
                    state_next = lps_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lps_pkg::S_IDLE;
            end
        endcase
    end

    // control state, calibration and threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lps_pkg::S_IDLE;
            ch_reg       <= '0;
            thr_reg      <= lps_pkg::THRESH_BITS'(lps_pkg::THRESH_RESET);
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < lps_pkg::CHANNELS; i++)
            begin
                max_reg[i] <= '0;
                min_reg[i] <= '1;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
            // channel walk
            if (in_acc)
            begin
                ch_reg <= '0;
            end
            else if (state_reg == lps_pkg::S_ACC && !last_ch)
            begin
                ch_reg <= ch_reg + 1'b1;
            end
            // running min and max
            if (state_reg == lps_pkg::S_CAL)
            begin
                if (cur_samp >= cur_max)
                begin
                    max_reg[ch_reg] <= cur_samp;
                end
                if (cur_samp <= cur_min)
                begin
                    min_reg[ch_reg] <= cur_samp;
                end
            end
            // output register handshake
            if (state_reg == lps_pkg::S_STEER && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        // capture samples
        if (in_acc)
        begin
            for (int i = 0; i < lps_pkg::CHANNELS; i++)
            begin
                samp_reg[i] <= s_tdata[i*lps_pkg::SAMPLE_BITS +: lps_pkg::SAMPLE_BITS];
            end
            sum_reg    <= '0;
            wsum_reg   <= '0;
            weight_reg <= '0;
        end
        // scaled reading
        if (state_reg == lps_pkg::S_MUL && span == '0)
        begin
            lv_reg <= '0;
        end
        else if (state_reg == lps_pkg::S_SDIV && div_rsp.done)
        begin
            lv_reg <= div_rsp.quotient[lps_pkg::LV_BITS-1:0];
        end
        // accumulate sum and weighted sum
        if (state_reg == lps_pkg::S_ACC)
        begin
            sum_reg    <= sum_reg + lps_pkg::SUM_BITS'(lv_reg);
            wsum_reg   <= wsum_reg + wterm;
            weight_reg <= weight_reg + lps_pkg::WEIGHT_BITS'(lps_pkg::SCALE_FULL);
        end
        // centroid
        if (state_reg == lps_pkg::S_CENT && sum_reg == '0)
        begin
            pos_reg  <= '0;
            none_reg <= 1'b1;
        end
        else if (state_reg == lps_pkg::S_CDIV && div_rsp.done)
        begin
            pos_reg  <= pos_clamp[lps_pkg::POS_BITS-1:0];
            none_reg <= 1'b0;
        end
        // steering into the output register
        if (state_reg == lps_pkg::S_STEER && out_free)
        begin
            pos_out_reg   <= pos_reg;
            err_out_reg   <= err_sat[lps_pkg::ERR_BITS-1:0];
            left_out_reg  <= !(err_sat <= -thr_s);
            right_out_reg <= !(err_sat >= thr_s);
            none_out_reg  <= none_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = none_out_reg;
    assign m_tdata  = {{(lps_pkg::OUT_WIDTH - lps_pkg::POS_BITS - lps_pkg::ERR_BITS - 2){1'b0}},
                       right_out_reg, left_out_reg, err_out_reg, pos_out_reg};

`ifndef SYNTH
    // a request keeps the block busy for at least the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_tready)
        else $error("input accepted again right after a request");

    // divider finishes only while the sequencer waits on it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == lps_pkg::S_SDIV || state_reg == lps_pkg::S_CDIV))
        else $error("divider result with no waiting state");

    // a division starts only on an idle divider
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("division started while the divider is busy");

    // a new result appears only out of the steering cycle
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == lps_pkg::S_STEER))
        else $error("result loaded outside the steering cycle");
`endif

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// self-checking testbench for the line position steering unit
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int QUIET_FROM     = 30000;
    localparam int QUIET_TO       = 60000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 212;
    localparam int DRAIN_CYCLES   = 100;
    localparam int LEFT_BIT       = lps_pkg::POS_BITS + lps_pkg::ERR_BITS;
    localparam int RIGHT_BIT      = LEFT_BIT + 1;
    localparam logic [lps_pkg::SAMPLE_BITS-1:0] FULL_SCALE = '1;

    typedef logic [lps_pkg::CHANNELS-1:0][lps_pkg::SAMPLE_BITS-1:0] sample_row_t;

    typedef struct packed {
        logic [lps_pkg::POS_BITS-1:0] position;
        logic [lps_pkg::ERR_BITS-1:0] error;
        logic                         left_on;
        logic                         right_on;
        logic                         no_line;
    } steer_result_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic [lps_pkg::IN_WIDTH-1:0]    s_tdata   = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [lps_pkg::OUT_WIDTH-1:0]   m_tdata;
    logic                            m_tuser;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [lps_pkg::THRESH_BITS-1:0] cfg_data  = '0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;

    // predictor state: calibration and threshold
    logic [lps_pkg::SAMPLE_BITS-1:0] cal_max [lps_pkg::CHANNELS];
    logic [lps_pkg::SAMPLE_BITS-1:0] cal_min [lps_pkg::CHANNELS];
    logic [lps_pkg::THRESH_BITS-1:0] steer_threshold =
        lps_pkg::THRESH_BITS'(lps_pkg::THRESH_RESET);

    logic [lps_pkg::IN_WIDTH-1:0]    sample_backlog [$];
    steer_result_t                   pending_steer [$];
    steer_result_t                   steer_due;

    bit                     in_taken      = 1'b0;
    int                     source_burst  = 0;
    int                     sink_burst    = 0;
    int                     cycle_count   = 0;
    int                     quiet_cycles  = 0;
    int                     result_index  = 0;
    int                     mismatch_count = 0;

    line_position_steering_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // reset and calibration state after reset
    initial
    begin
        for (int ch = 0; ch < lps_pkg::CHANNELS; ch++)
        begin
            cal_max[ch] = '0;
            cal_min[ch] = FULL_SCALE;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch at result %0d, %s: got %0d, expected %0d",
                 result_index, field, got, want);
        mismatch_count++;
    endtask

    // random idling: short gaps, rare long bursts, none in the quiet window
    function automatic bit take_break(inout int burst_left);
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
        begin
            burst_left = 0;
            return 1'b0;
        end
        if (burst_left > 0)
        begin
            burst_left--;
            return 1'b1;
        end
        if ($urandom_range(0, 499) == 0)
        begin
            burst_left = $urandom_range(20, 150);
            return 1'b1;
        end
        return ($urandom_range(0, 99) < 28);
    endfunction

    // calibration update, scaling, centroid and steering decision
    function automatic steer_result_t steer_from_samples(input sample_row_t row);
        steer_result_t                   res;
        logic [lps_pkg::SAMPLE_BITS-1:0] s;
        longint unsigned                 offset, span, level, level_sum, weight_sum, centroid;
        int                              err, thr, quot;
        level_sum  = 0;
        weight_sum = 0;
        centroid   = 0;
        for (int ch = 0; ch < lps_pkg::CHANNELS; ch++)
        begin
            s = row[ch];
            if (s >= cal_max[ch])
                cal_max[ch] = s;
            if (s <= cal_min[ch])
                cal_min[ch] = s;
            offset = s - cal_min[ch];
            span   = cal_max[ch] - cal_min[ch];
            level  = 0;
            if (span != 0)
                level = (offset * lps_pkg::SCALE_FULL) / span;
            level_sum  += level;
            weight_sum += level * longint'(ch) * lps_pkg::SCALE_FULL;
        end
        res.no_line = (level_sum == 0);
        if (!res.no_line)
            centroid = weight_sum / level_sum;
        if (centroid > lps_pkg::POS_MAX)
            centroid = lps_pkg::POS_MAX;
        err = int'(centroid) - lps_pkg::CENTER;
        if (err > lps_pkg::ERR_MAX)
            err = lps_pkg::ERR_MAX;
        if (err < lps_pkg::ERR_MIN)
            err = lps_pkg::ERR_MIN;
        // a zero threshold acts as one
        thr  = (steer_threshold == 0) ? 1 : int'(steer_threshold);
        quot = err / thr;
        res.position = centroid[lps_pkg::POS_BITS-1:0];
        res.error    = err[lps_pkg::ERR_BITS-1:0];
        res.left_on  = (quot >= 0);
        res.right_on = (quot <= 0);
        return res;
    endfunction

    // mostly line-shaped rows, some uniform noise, some degenerate rows
    function automatic sample_row_t random_samples();
        sample_row_t row;
        int          pick, peak, side, level;
        pick  = $urandom_range(0, 99);
        peak  = $urandom_range(0, lps_pkg::CHANNELS - 1);
        level = $urandom_range(0, 4095);
        for (int ch = 0; ch < lps_pkg::CHANNELS; ch++)
            row[ch] = lps_pkg::SAMPLE_BITS'($urandom_range(0, 400));
        if (pick < 60)
        begin
            side = (peak == 0 || (peak < lps_pkg::CHANNELS - 1 && $urandom_range(0, 1) == 1))
                   ? peak + 1 : peak - 1;
            row[peak] = lps_pkg::SAMPLE_BITS'($urandom_range(2500, 4095));
            row[side] = lps_pkg::SAMPLE_BITS'($urandom_range(0, 4095));
        end
        else if (pick < 85)
        begin
            for (int ch = 0; ch < lps_pkg::CHANNELS; ch++)
                row[ch] = lps_pkg::SAMPLE_BITS'($urandom());
        end
        else if (pick < 90)
        begin
            row       = '0;
            row[peak] = lps_pkg::SAMPLE_BITS'(level);
        end
        else if (pick < 95)
        begin
            for (int ch = 0; ch < lps_pkg::CHANNELS; ch++)
                row[ch] = lps_pkg::SAMPLE_BITS'(level);
        end
        else
            row = '0;
        return row;
    endfunction

    function automatic sample_row_t uniform_row(input logic [lps_pkg::SAMPLE_BITS-1:0] value);
        sample_row_t row;
        for (int ch = 0; ch < lps_pkg::CHANNELS; ch++)
            row[ch] = value;
        return row;
    endfunction

    task automatic queue_row(input sample_row_t row);
        sample_backlog.push_back(lps_pkg::IN_WIDTH'(row));
    endtask

    // wait until every request is taken and every result has come back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (sample_backlog.size() != 0 || (s_tvalid && !in_taken) ||
               pending_steer.size() != 0);
    endtask

    task automatic write_threshold(input logic [lps_pkg::THRESH_BITS-1:0] value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        steer_threshold = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_taken)
        begin
            in_taken = 1'b0;
            if (sample_backlog.size() != 0 && !take_break(source_burst))
            begin
                s_tdata  <= sample_backlog.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result backpressure
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !take_break(sink_burst);
    end

    // monitor: predict on accepted requests, check accepted results, watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && s_tvalid && s_tready)
        begin
            pending_steer.push_back(
                steer_from_samples(s_tdata[lps_pkg::CHANNELS*lps_pkg::SAMPLE_BITS-1:0]));
            in_taken = 1'b1;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_steer.size() == 0)
                report_mismatch("result with nothing pending", int'(m_tdata), 0);
            else
            begin
                steer_due = pending_steer.pop_front();
                if (m_tdata[lps_pkg::POS_BITS-1:0] != steer_due.position)
                    report_mismatch("line_position", int'(m_tdata[lps_pkg::POS_BITS-1:0]),
                                    int'(steer_due.position));
                if (m_tdata[LEFT_BIT-1:lps_pkg::POS_BITS] != steer_due.error)
                    report_mismatch("position_error",
                                    int'(m_tdata[LEFT_BIT-1:lps_pkg::POS_BITS]),
                                    int'(steer_due.error));
                if (m_tdata[LEFT_BIT] != steer_due.left_on)
                    report_mismatch("left_on", int'(m_tdata[LEFT_BIT]),
                                    int'(steer_due.left_on));
                if (m_tdata[RIGHT_BIT] != steer_due.right_on)
                    report_mismatch("right_on", int'(m_tdata[RIGHT_BIT]),
                                    int'(steer_due.right_on));
                if (m_tuser != steer_due.no_line)
                    report_mismatch("no_line", int'(m_tuser), int'(steer_due.no_line));
            end
            result_index++;
        end
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // stimulus phases
    initial
    begin
        sample_row_t                     row;
        logic [lps_pkg::THRESH_BITS-1:0] thr_value;
        wait (rst_n);

        // directed part under the reset threshold
        queue_row('0);                       // every channel flat: no line
        row = '0;
        row[0] = FULL_SCALE;
        queue_row(row);                      // only channel 0 calibrated, others still flat
        queue_row(uniform_row(FULL_SCALE));
        queue_row('0);                       // calibrated, all at minimum: no line
        for (int k = 0; k < lps_pkg::CHANNELS; k++)
        begin
            row = '0;
            row[k] = FULL_SCALE;
            queue_row(row);                  // line exactly under one sensor
        end
        row = '0;
        row[2] = FULL_SCALE;
        row[3] = FULL_SCALE;
        queue_row(row);                      // error exactly at plus threshold
        row = '0;
        row[1] = FULL_SCALE;
        row[2] = FULL_SCALE;
        queue_row(row);                      // error exactly at minus threshold
        row = '0;
        row[0] = FULL_SCALE;
        row[lps_pkg::CHANNELS-1] = FULL_SCALE;
        queue_row(row);
        queue_row(uniform_row(12'd2048));
        queue_row(uniform_row(12'd1));       // scaled readings round down to zero
        row = '0;
        row[lps_pkg::CHANNELS-1] = 12'd5;
        queue_row(row);                      // far edge from a tiny reading
        for (int k = 0; k < lps_pkg::CHANNELS; k++)
            row[k] = (k % 2 == 0) ? 12'hAAA : 12'h555;
        queue_row(row);
        for (int k = 0; k < lps_pkg::CHANNELS; k++)
            row[k] = (k % 2 == 0) ? 12'h555 : 12'hAAA;
        queue_row(row);
        queue_row(uniform_row(FULL_SCALE));
        wait_idle();

        // random part over several thresholds, extremes first
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       thr_value = 11'd1;
                1:       thr_value = 11'd2000;
                2:       thr_value = 11'd0;
                3:       thr_value = '1;
                4:       thr_value = lps_pkg::THRESH_BITS'($urandom_range(1, 50));
                default: thr_value = lps_pkg::THRESH_BITS'($urandom_range(1, 2000));
            endcase
            write_threshold(thr_value);
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_row(random_samples());
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_steer.size() != 0)
            report_mismatch("results never delivered", 0, pending_steer.size());
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/core/lps_pkg.sv
rtl/core/lps_div.sv
rtl/core/line_position_steering_unit.sv
sim/tb_top.sv
